// ===== src/assert_macros.svh =====
// Assertion macros shared by the console writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TMCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define TMCW_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== src/tmcw_pkg.sv =====
// Types, constants and controller/datapath interface of the text console writer.
package tmcw_pkg;

  // Screen geometry
  localparam int TEXT_COLUMNS = 80;
  localparam int TEXT_ROWS    = 25;
  localparam int CELL_COUNT   = TEXT_COLUMNS * TEXT_ROWS;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  // Derived internal widths
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int POS_W  = $clog2(CELL_COUNT + TEXT_COLUMNS);
  localparam int COL_W  = $clog2(TEXT_COLUMNS);

  // Sweep counter limits
  localparam logic [CNT_W-1:0] CELLS_C     = CNT_W'(CELL_COUNT);
  localparam logic [CNT_W-1:0] COPY_LEN_C  = CNT_W'(CELL_COUNT - TEXT_COLUMNS);
  localparam logic [CNT_W-1:0] INIT_LAST_C = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] COLS_CNT_C  = CNT_W'(TEXT_COLUMNS);

  // Cursor arithmetic constants
  localparam logic [POS_W-1:0] CELLS_POS_C = POS_W'(CELL_COUNT);
  localparam logic [POS_W-1:0] COLS_POS_C  = POS_W'(TEXT_COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST_C  = COL_W'(TEXT_COLUMNS - 1);

  // Cell and character codes
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0f20;
  localparam logic [7:0]        ATTR_WHITE   = 8'h0f;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CODE_BACKSP  = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'h20;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Request and response payloads
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } in_req_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_value;
  } out_rsp_t;

  // Screen memory operations driven by the controller
  typedef enum logic [2:0] {
    MEM_NONE      = 3'd0,
    MEM_INIT      = 3'd1,
    MEM_PUT       = 3'd2,
    MEM_COPY      = 3'd3,
    MEM_BLANK_ROW = 3'd4,
    MEM_BLANK_CUR = 3'd5,
    MEM_CLEAR     = 3'd6,
    MEM_READ      = 3'd7
  } mem_op_e;

  typedef struct packed {
    logic    load;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cur_put;
    logic    cur_home;
    logic    out_load;
    mem_op_e mem_op;
  } dp_cmd_t;

  typedef struct packed {
    logic scroll;
    logic copy_last;
    logic sweep_end;
    logic init_last;
  } dp_stat_t;

endpackage

// ===== src/tmcw_datapath.sv =====
// Console datapath: screen memory, cursor, sweep counter and response register.
`include "assert_macros.svh"

module tmcw_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmcw_pkg::in_req_t  in_req_i,
  input  tmcw_pkg::dp_cmd_t  cmd_i,
  output tmcw_pkg::dp_stat_t stat_o,
  output tmcw_pkg::out_rsp_t out_rsp_o
);

  tmcw_pkg::in_req_t  req_q;
  tmcw_pkg::out_rsp_t rsp_q;

  logic [tmcw_pkg::ADDR_W-1:0] cursor_q, cursor_d;
  logic [tmcw_pkg::COL_W-1:0]  col_q, col_d;
  logic [tmcw_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  logic [tmcw_pkg::CELL_W-1:0] screen_mem_q [tmcw_pkg::CELL_COUNT];
  logic [tmcw_pkg::CELL_W-1:0] rd_data_q;

  logic                        mem_we, mem_re;
  logic [tmcw_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [tmcw_pkg::CELL_W-1:0] wr_data;

  logic [tmcw_pkg::POS_W-1:0]  cur_ext, pos_raw, pos_fin;
  logic [tmcw_pkg::COL_W-1:0]  col_new;
  logic                        is_nl, is_bs, is_plain, idx_ok;
  logic [tmcw_pkg::CNT_W-1:0]  cnt_m1, cnt_up;
  logic [tmcw_pkg::CELL_W-1:0] value_sel;

  // Character classes of the latched request
  assign is_nl    = (req_q.char_code == tmcw_pkg::CODE_NEWLINE);
  assign is_bs    = (req_q.char_code == tmcw_pkg::CODE_BACKSP);
  assign is_plain = !is_nl && !is_bs;
  assign idx_ok   = ({1'b0, req_q.cell_index} < {1'b0, tmcw_pkg::INDEX_W'(tmcw_pkg::CELL_COUNT)});
  assign cur_ext  = tmcw_pkg::POS_W'(cursor_q);

  // Cursor move of a put, with the one-row pull-back on scroll
  always_comb begin
    pos_raw = cur_ext;
    col_new = col_q;
    if (is_nl) begin
      pos_raw = cur_ext + tmcw_pkg::COLS_POS_C - tmcw_pkg::POS_W'(col_q);
      col_new = '0;
    end else if (is_bs) begin
      if (cursor_q != '0) begin
        pos_raw = cur_ext - tmcw_pkg::POS_W'(1);
        col_new = (col_q == '0) ? tmcw_pkg::COL_LAST_C : col_q - tmcw_pkg::COL_W'(1);
      end
    end else begin
      pos_raw = cur_ext + tmcw_pkg::POS_W'(1);
      col_new = (col_q == tmcw_pkg::COL_LAST_C) ? '0 : col_q + tmcw_pkg::COL_W'(1);
    end
  end

  assign stat_o.scroll = (pos_raw >= tmcw_pkg::CELLS_POS_C);
  assign pos_fin = stat_o.scroll ? pos_raw - tmcw_pkg::COLS_POS_C : pos_raw;

  // Sweep status
  assign stat_o.copy_last = (cnt_q == tmcw_pkg::COPY_LEN_C);
  assign stat_o.sweep_end = (cnt_q == tmcw_pkg::CELLS_C);
  assign stat_o.init_last = (cnt_q == tmcw_pkg::INIT_LAST_C);

  assign cnt_m1 = cnt_q - tmcw_pkg::CNT_W'(1);
  assign cnt_up = cnt_q + tmcw_pkg::COLS_CNT_C;

  // Next values of cursor and counter
  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    if (cmd_i.cur_home) begin
      cursor_d = '0;
      col_d    = '0;
    end else if (cmd_i.cur_put) begin
      cursor_d = pos_fin[tmcw_pkg::ADDR_W-1:0];
      col_d    = col_new;
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + tmcw_pkg::CNT_W'(1);
    end
  end

  // Memory port control; copy and clear sweeps write each cell in the cycle after its read
  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    wr_addr = cursor_q;
    rd_addr = cnt_q[tmcw_pkg::ADDR_W-1:0];
    wr_data = tmcw_pkg::BLANK_CELL;
    case (cmd_i.mem_op)
      tmcw_pkg::MEM_INIT: begin
        mem_we  = 1'b1;
        wr_addr = cnt_q[tmcw_pkg::ADDR_W-1:0];
      end
      tmcw_pkg::MEM_PUT: begin
        mem_we  = is_plain;
        wr_data = {tmcw_pkg::ATTR_WHITE, req_q.char_code};
      end
      tmcw_pkg::MEM_COPY: begin
        mem_re  = (cnt_q < tmcw_pkg::COPY_LEN_C);
        rd_addr = cnt_up[tmcw_pkg::ADDR_W-1:0];
        mem_we  = (cnt_q != '0);
        wr_addr = cnt_m1[tmcw_pkg::ADDR_W-1:0];
        wr_data = rd_data_q;
      end
      tmcw_pkg::MEM_BLANK_ROW: begin
        mem_we  = 1'b1;
        wr_addr = cnt_m1[tmcw_pkg::ADDR_W-1:0];
      end
      tmcw_pkg::MEM_BLANK_CUR: begin
        mem_we = 1'b1;
      end
      tmcw_pkg::MEM_CLEAR: begin
        mem_re  = (cnt_q < tmcw_pkg::CELLS_C);
        mem_we  = (cnt_q != '0);
        wr_addr = cnt_m1[tmcw_pkg::ADDR_W-1:0];
        wr_data = {rd_data_q[tmcw_pkg::CELL_W-1:8], tmcw_pkg::CODE_SPACE};
      end
      tmcw_pkg::MEM_READ: begin
        mem_re  = idx_ok;
        rd_addr = req_q.cell_index[tmcw_pkg::ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Screen memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem_q[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= screen_mem_q[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
    end else begin
      cursor_q <= cursor_d;
      col_q    <= col_d;
      cnt_q    <= cnt_d;
    end
  end

  // Response value: only a read in range returns a cell
  assign value_sel = (req_q.cmd == tmcw_pkg::CMD_READ && idx_ok) ? rd_data_q : '0;

  // Latched request and response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (cmd_i.out_load) begin
      rsp_q.cursor_pos <= tmcw_pkg::CURSOR_W'(cursor_q);
      rsp_q.cell_value <= value_sel;
    end
  end

  assign out_rsp_o = rsp_q;

  `TMCW_ASSERT(a_wr_in_range, mem_we |-> (int'(wr_addr) < tmcw_pkg::CELL_COUNT), "write beyond screen")
  `TMCW_ASSERT(a_cursor_in_range, int'(cursor_q) < tmcw_pkg::CELL_COUNT, "cursor off screen")
  `TMCW_ASSERT(a_col_in_range, int'(col_q) < tmcw_pkg::TEXT_COLUMNS, "column off screen")

endmodule

// ===== src/tmcw_ctrl.sv =====
// Console controller: sequences puts, scrolls, clears, reads and the power-up blanking.
`include "assert_macros.svh"

module tmcw_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [tmcw_pkg::CMD_W-1:0] in_cmd_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  tmcw_pkg::dp_stat_t         stat_i,
  output tmcw_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_PUT    = 9'b000000100,
    S_SCROLL = 9'b000001000,
    S_BLANK  = 9'b000010000,
    S_FINAL  = 9'b000100000,
    S_CLEAR  = 9'b001000000,
    S_READ   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{mem_op: tmcw_pkg::MEM_NONE, default: 1'b0};
    case (state_q)
      S_INIT: begin
        cmd_o.mem_op  = tmcw_pkg::MEM_INIT;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.init_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load    = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          case (in_cmd_i)
            tmcw_pkg::CMD_PUT:   state_d = S_PUT;
            tmcw_pkg::CMD_CLEAR: state_d = S_CLEAR;
            tmcw_pkg::CMD_READ:  state_d = S_READ;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        cmd_o.mem_op  = tmcw_pkg::MEM_PUT;
        cmd_o.cur_put = 1'b1;
        state_d       = stat_i.scroll ? S_SCROLL : S_FINAL;
      end
      S_SCROLL: begin
        cmd_o.mem_op  = tmcw_pkg::MEM_COPY;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.copy_last) begin
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd_o.mem_op  = tmcw_pkg::MEM_BLANK_ROW;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.sweep_end) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd_o.mem_op = tmcw_pkg::MEM_BLANK_CUR;
        state_d      = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.mem_op  = tmcw_pkg::MEM_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.sweep_end) begin
          cmd_o.cur_home = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.mem_op = tmcw_pkg::MEM_READ;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // wait for the response register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Response valid flag
  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TMCW_NEVER(a_no_overwrite, cmd_o.out_load && out_valid_q && !out_ready_i, "response overwritten")
  `TMCW_ASSERT(a_accept_leaves_idle, accept |=> (state_q != S_IDLE), "request accepted but not run")
  `TMCW_ASSERT(a_scroll_then_blank, (state_q == S_SCROLL) && stat_i.copy_last |=> (state_q == S_BLANK), "scroll did not blank bottom row")

endmodule

// ===== src/text_mode_console_writer_core.sv =====
// Top level of the text-mode console writer: controller plus datapath.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_ready_o   in_req_i  (cmd, char_code, cell_index)
//   out      response   out_valid_o / out_ready_i out_rsp_o (cursor_pos, cell_value)
//
// One request at a time; the response becomes valid once the command is done. A read fetches
// the cell, a put writes and blanks the cell under the new cursor, and a put that scrolls also
// copies the rows up and blanks the bottom row; a clear sweeps all CELL_COUNT cells.
// The screen memory, one read and one write a cycle, sets the sweep lengths.
// After reset a blanking pass over all CELL_COUNT cells (2000) runs before the first request.
// A waiting response sits in its own register; the next request is taken meanwhile.
module text_mode_console_writer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tmcw_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tmcw_pkg::out_rsp_t out_rsp_o
);

  tmcw_pkg::dp_cmd_t  dp_cmd;
  tmcw_pkg::dp_stat_t dp_stat;

  // Sequencer
  tmcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_req_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // Screen memory and cursor
  tmcw_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat),
    .out_rsp_o (out_rsp_o)
  );

endmodule

// ===== bench/tb_text_mode_console_writer_core.sv =====
// Self-checking testbench for the text-mode console writer core.
module tb_text_mode_console_writer_core;

  // Command code with no operation behind it
  localparam logic [tmcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Watchdog: every item scrolling, with long gaps and stalls, several times over
  localparam int LIMIT_CYCLES = 4_000_000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  tmcw_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  tmcw_pkg::out_rsp_t out_rsp_o;

  // Shadow copy of the screen and cursor
  logic [tmcw_pkg::CELL_W-1:0] shadow_screen [tmcw_pkg::CELL_COUNT];
  int                          shadow_cursor;

  // Responses still owed by the block, oldest first
  tmcw_pkg::out_rsp_t console_rsp_q [$];

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;

  text_mode_console_writer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Clock, period 2
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Apply one request to the shadow screen and return the response it earns
  function automatic tmcw_pkg::out_rsp_t console_response(tmcw_pkg::in_req_t req);
    tmcw_pkg::out_rsp_t rsp;
    int                 pos;
    int                 i;
    rsp.cell_value = '0;
    case (req.cmd)
      tmcw_pkg::CMD_PUT: begin
        pos = shadow_cursor;
        if (req.char_code == tmcw_pkg::CODE_NEWLINE) begin
          pos = pos + tmcw_pkg::TEXT_COLUMNS - pos % tmcw_pkg::TEXT_COLUMNS;
        end else if (req.char_code == tmcw_pkg::CODE_BACKSP) begin
          if (pos > 0) pos--;
        end else begin
          shadow_screen[pos] = {tmcw_pkg::ATTR_WHITE, req.char_code};
          pos++;
        end
        // Past the last cell: scroll up one row and blank the bottom row
        if (pos >= tmcw_pkg::CELL_COUNT) begin
          for (i = 0; i < tmcw_pkg::CELL_COUNT - tmcw_pkg::TEXT_COLUMNS; i++)
            shadow_screen[i] = shadow_screen[i + tmcw_pkg::TEXT_COLUMNS];
          for (i = tmcw_pkg::CELL_COUNT - tmcw_pkg::TEXT_COLUMNS; i < tmcw_pkg::CELL_COUNT; i++)
            shadow_screen[i] = tmcw_pkg::BLANK_CELL;
          pos -= tmcw_pkg::TEXT_COLUMNS;
        end
        shadow_cursor = pos;
        shadow_screen[pos] = tmcw_pkg::BLANK_CELL;
      end
      tmcw_pkg::CMD_CLEAR: begin
        for (i = 0; i < tmcw_pkg::CELL_COUNT; i++)
          shadow_screen[i] = {shadow_screen[i][15:8], tmcw_pkg::CODE_SPACE};
        shadow_cursor = 0;
      end
      tmcw_pkg::CMD_READ: begin
        if (req.cell_index < tmcw_pkg::CELL_COUNT)
          rsp.cell_value = shadow_screen[req.cell_index];
      end
      default: ;
    endcase
    rsp.cursor_pos = tmcw_pkg::CURSOR_W'(shadow_cursor);
    return rsp;
  endfunction

  // A character byte that is neither newline nor backspace
  function automatic logic [tmcw_pkg::CHAR_W-1:0] plain_char();
    logic [tmcw_pkg::CHAR_W-1:0] code;
    code = tmcw_pkg::CHAR_W'($urandom);
    while (code == tmcw_pkg::CODE_NEWLINE || code == tmcw_pkg::CODE_BACKSP)
      code = tmcw_pkg::CHAR_W'($urandom);
    return code;
  endfunction

  // Offer one request, with random idle cycles first, and wait for it to be taken
  task automatic send_request(input logic [tmcw_pkg::CMD_W-1:0] cmd,
                              input logic [tmcw_pkg::CHAR_W-1:0] code,
                              input logic [tmcw_pkg::INDEX_W-1:0] index);
    tmcw_pkg::in_req_t req;
    req.cmd        = cmd;
    req.char_code  = code;
    req.cell_index = index;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    console_rsp_q.push_back(console_response(req));
  endtask

  // Response side: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every response taken with the oldest one owed
  always @(posedge clk_i) begin : rsp_check
    tmcw_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (console_rsp_q.size() == 0) begin
        $display("%0t: response with none owed: cursor %0d cell %h", $time,
                 out_rsp_o.cursor_pos, out_rsp_o.cell_value);
        error_count++;
      end else begin
        want = console_rsp_q.pop_front();
        if (out_rsp_o.cursor_pos !== want.cursor_pos) begin
          $display("%0t: cursor_pos expected %0d actual %0d", $time,
                   want.cursor_pos, out_rsp_o.cursor_pos);
          error_count++;
        end
        if (out_rsp_o.cell_value !== want.cell_value) begin
          $display("%0t: cell_value expected %h actual %h", $time,
                   want.cell_value, out_rsp_o.cell_value);
          error_count++;
        end
      end
    end
  end

  // Fresh screen: blank cells, and out-of-range reads give zero
  task automatic test_reset_contents();
    send_request(tmcw_pkg::CMD_READ, 8'h00, 11'd0);
    send_request(tmcw_pkg::CMD_READ, 8'hff, tmcw_pkg::INDEX_W'(tmcw_pkg::CELL_COUNT - 1));
    send_request(tmcw_pkg::CMD_READ, 8'h00, tmcw_pkg::INDEX_W'(tmcw_pkg::CELL_COUNT));
    send_request(tmcw_pkg::CMD_READ, 8'hff, 11'h7ff);
  endtask

  // Ordinary bytes, the extreme codes included
  task automatic test_put_characters();
    send_request(tmcw_pkg::CMD_PUT, 8'h41, 11'h7ff);
    send_request(tmcw_pkg::CMD_PUT, 8'h00, 11'd0);
    send_request(tmcw_pkg::CMD_PUT, 8'hff, 11'd0);
    for (int i = 0; i < 4; i++)
      send_request(tmcw_pkg::CMD_READ, 8'h00, tmcw_pkg::INDEX_W'(i));
  endtask

  // Backspace, including one at the home position
  task automatic test_backspace();
    send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_BACKSP, 11'd0);
    send_request(tmcw_pkg::CMD_READ, 8'h00, 11'd2);
    send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_BACKSP, 11'd0);
    send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_BACKSP, 11'd0);
    send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_BACKSP, 11'd0);
    send_request(tmcw_pkg::CMD_READ, 8'h00, 11'd0);
  endtask

  task automatic test_newline();
    send_request(tmcw_pkg::CMD_PUT, 8'h7e, 11'd0);
    send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_NEWLINE, 11'd0);
    send_request(tmcw_pkg::CMD_READ, 8'h00, 11'd0);
    send_request(tmcw_pkg::CMD_READ, 8'h00, 11'd1);
    send_request(tmcw_pkg::CMD_READ, 8'h00, tmcw_pkg::INDEX_W'(tmcw_pkg::TEXT_COLUMNS));
  endtask

  task automatic test_unused_command();
    send_request(CMD_UNUSED, 8'hff, 11'h7ff);
  endtask

  task automatic test_clear_screen();
    send_request(tmcw_pkg::CMD_CLEAR, 8'h00, 11'd0);
    send_request(tmcw_pkg::CMD_READ, 8'h00, 11'd0);
  endtask

  // Walk to the bottom row, fill it so the last cell scrolls, then scroll by newline
  task automatic test_scroll();
    int last_row;
    last_row = tmcw_pkg::CELL_COUNT - tmcw_pkg::TEXT_COLUMNS;
    send_request(tmcw_pkg::CMD_CLEAR, tmcw_pkg::CHAR_W'($urandom),
                 tmcw_pkg::INDEX_W'($urandom));
    for (int i = 0; i < tmcw_pkg::TEXT_ROWS - 1; i++)
      send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_NEWLINE, tmcw_pkg::INDEX_W'($urandom));
    for (int i = 0; i < tmcw_pkg::TEXT_COLUMNS; i++)
      send_request(tmcw_pkg::CMD_PUT, plain_char(), tmcw_pkg::INDEX_W'($urandom));
    send_request(tmcw_pkg::CMD_READ, 8'h00,
                 tmcw_pkg::INDEX_W'(last_row - tmcw_pkg::TEXT_COLUMNS));
    send_request(tmcw_pkg::CMD_READ, 8'h00, tmcw_pkg::INDEX_W'(last_row - 1));
    send_request(tmcw_pkg::CMD_READ, 8'h00, tmcw_pkg::INDEX_W'(last_row));
    send_request(tmcw_pkg::CMD_READ, 8'h00, tmcw_pkg::INDEX_W'(tmcw_pkg::CELL_COUNT - 1));
    send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_NEWLINE, tmcw_pkg::INDEX_W'($urandom));
    send_request(tmcw_pkg::CMD_READ, 8'h00,
                 tmcw_pkg::INDEX_W'(last_row - 2 * tmcw_pkg::TEXT_COLUMNS + 5));
    send_request(tmcw_pkg::CMD_READ, 8'h00, tmcw_pkg::INDEX_W'(last_row - 1));
  endtask

  // Long hold on the response side while requests keep coming
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    for (int i = 0; i < 10; i++) begin
      if (i % 2 == 0) begin
        send_request(tmcw_pkg::CMD_PUT, plain_char(), tmcw_pkg::INDEX_W'($urandom));
      end else begin
        send_request(tmcw_pkg::CMD_READ, tmcw_pkg::CHAR_W'($urandom),
                     tmcw_pkg::INDEX_W'(shadow_cursor));
      end
    end
  endtask

  // Random mix of commands; reads favour cells round the cursor
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
    int sel;
    int idx;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CHAR_W'($urandom),
                     tmcw_pkg::INDEX_W'($urandom));
      end else if (sel < 62) begin
        send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_NEWLINE, tmcw_pkg::INDEX_W'($urandom));
      end else if (sel < 72) begin
        send_request(tmcw_pkg::CMD_PUT, tmcw_pkg::CODE_BACKSP, tmcw_pkg::INDEX_W'($urandom));
      end else if (sel < 94) begin
        case ($urandom_range(9))
          0:          idx = $urandom_range(2047, tmcw_pkg::CELL_COUNT);
          1, 2, 3, 4: idx = $urandom_range(tmcw_pkg::CELL_COUNT - 1);
          default: begin
            idx = shadow_cursor + int'($urandom_range(6)) - 3;
            if (idx < 0) idx = 0;
          end
        endcase
        send_request(tmcw_pkg::CMD_READ, tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::INDEX_W'(idx));
      end else if (sel < 97) begin
        send_request(CMD_UNUSED, tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::INDEX_W'($urandom));
      end else begin
        send_request(tmcw_pkg::CMD_CLEAR, tmcw_pkg::CHAR_W'($urandom),
                     tmcw_pkg::INDEX_W'($urandom));
      end
    end
  endtask

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb_text_mode_console_writer_core: FAIL");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    for (int i = 0; i < tmcw_pkg::CELL_COUNT; i++) shadow_screen[i] = tmcw_pkg::BLANK_CELL;
    shadow_cursor = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_contents();
    test_put_characters();
    test_backspace();
    test_newline();
    test_unused_command();
    test_clear_screen();
    test_scroll();
    test_output_backpressure();
    run_random_phase(0, 0, 50);
    run_random_phase(75, 0, 50);
    run_random_phase(0, 75, 50);
    run_random_phase(25, 25, 50);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (console_rsp_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && console_rsp_q.size() == 0) begin
      $display("tb_text_mode_console_writer_core: PASS");
    end else begin
      $display("tb_text_mode_console_writer_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== text_mode_console_writer_core.f =====
+incdir+src
src/tmcw_pkg.sv
src/tmcw_datapath.sv
src/tmcw_ctrl.sv
src/text_mode_console_writer_core.sv
bench/tb_text_mode_console_writer_core.sv
